// File: hdl/tfn_pkg.sv
package tfn_pkg;

	localparam int COORD_W  = 16;
	localparam int FRAC_W   = 14;
	localparam int OUT_W    = 16;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * EDGE_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int MAG_W    = PROD_W;
	localparam int POS_W    = 6;
	localparam int U_W      = 30;
	localparam int NORM_POS = U_W - 1;
	localparam int SQ_W     = 2 * U_W;
	localparam int S_W      = SQ_W + 2;
	localparam int ROOT_STEPS = S_W / 2;
	localparam int L_W      = ROOT_STEPS;
	localparam int D_W      = L_W + 1;
	localparam int Q_W      = FRAC_W + 2;
	localparam int REM_W    = U_W + FRAC_W + 3;

	typedef struct packed {
		logic [S_W-1:0]           rem;
		logic [S_W-1:0]           res;
		logic [2:0][U_W-1:0]      u;
		logic [2:0]               neg;
		logic                     degen;
	} sq_t;

	typedef struct packed {
		logic [2:0][REM_W-1:0]    rem;
		logic [2:0][Q_W-1:0]      q;
		logic [D_W-1:0]           d;
		logic [2:0]               neg;
		logic                     degen;
	} div_t;

endpackage

// File: hdl/tfn_front.sv
module tfn_front
	import tfn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [8:0][COORD_W-1:0] in_vtx,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sq_t                   out_data
);

	logic [7:1] vld_q;
	logic [6:0] vld_c;
	logic [8:1] adv;

	logic signed [EDGE_W-1:0]  edge_s1 [6];
	logic signed [PROD_W-1:0]  prod_s2 [6];
	logic [2:0][MAG_W-1:0]     mag_s3, mag_s4;
	logic [2:0]                neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic                      degen_s3, degen_s4, degen_s5, degen_s6, degen_s7;
	logic                      left_s4;
	logic [POS_W-1:0]          amt_s4;
	logic [2:0][U_W-1:0]       u_s5, u_s6, u_s7;
	logic [2:0][SQ_W-1:0]      sq_s6;
	logic [S_W-1:0]            sum_s7;

	logic signed [EDGE_W-1:0]  edge_c [6];
	logic signed [CROSS_W-1:0] cross_c [3];
	logic [2:0][MAG_W-1:0]     mag_c;
	logic [2:0][U_W-1:0]       u_c;
	logic [MAG_W-1:0]          or_c;
	logic [POS_W-1:0]          pos_c;

	assign adv[8] = out_ready;
	genvar g;
	generate
		for (g = 1; g <= 7; g++) begin : g_adv
			assign adv[g] = ~vld_q[g] | adv[g+1];
		end
	endgenerate
	assign in_ready  = adv[1];
	assign out_valid = vld_q[7];
	assign vld_c     = {vld_q[6:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= 7; k++) begin
				if (adv[k]) vld_q[k] <= vld_c[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			edge_c[i]   = EDGE_W'($signed(in_vtx[i]))   - EDGE_W'($signed(in_vtx[3+i]));
			edge_c[3+i] = EDGE_W'($signed(in_vtx[3+i])) - EDGE_W'($signed(in_vtx[6+i]));
		end
	end

	always_comb begin
		cross_c[0] = CROSS_W'(prod_s2[0]) - CROSS_W'(prod_s2[1]);
		cross_c[1] = CROSS_W'(prod_s2[2]) - CROSS_W'(prod_s2[3]);
		cross_c[2] = CROSS_W'(prod_s2[4]) - CROSS_W'(prod_s2[5]);
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = cross_c[i][CROSS_W-1] ? MAG_W'(-cross_c[i]) : MAG_W'(cross_c[i]);
		end
	end

	always_comb begin
		or_c  = mag_s3[0] | mag_s3[1] | mag_s3[2];
		pos_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (or_c[b]) pos_c = POS_W'(b);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c[i] = left_s4 ? U_W'(mag_s4[i] << amt_s4) : U_W'(mag_s4[i] >> amt_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && vld_c[0]) edge_s1 <= edge_c;
		if (adv[2] && vld_c[1]) begin
			prod_s2[0] <= edge_s1[1] * edge_s1[5];
			prod_s2[1] <= edge_s1[2] * edge_s1[4];
			prod_s2[2] <= edge_s1[2] * edge_s1[3];
			prod_s2[3] <= edge_s1[0] * edge_s1[5];
			prod_s2[4] <= edge_s1[0] * edge_s1[4];
			prod_s2[5] <= edge_s1[1] * edge_s1[3];
		end
		if (adv[3] && vld_c[2]) begin
			mag_s3   <= mag_c;
			neg_s3   <= {cross_c[2][CROSS_W-1], cross_c[1][CROSS_W-1], cross_c[0][CROSS_W-1]};
			degen_s3 <= (cross_c[0] == '0) && (cross_c[1] == '0) && (cross_c[2] == '0);
		end
		if (adv[4] && vld_c[3]) begin
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
			degen_s4 <= degen_s3;
			left_s4  <= pos_c < POS_W'(NORM_POS);
			amt_s4   <= (pos_c < POS_W'(NORM_POS)) ? POS_W'(NORM_POS) - pos_c
			                                       : pos_c - POS_W'(NORM_POS);
		end
		if (adv[5] && vld_c[4]) begin
			u_s5     <= u_c;
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;
		end
		if (adv[6] && vld_c[5]) begin
			for (int i = 0; i < 3; i++) sq_s6[i] <= SQ_W'(u_s5[i]) * SQ_W'(u_s5[i]);
			u_s6     <= u_s5;
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
		end
		if (adv[7] && vld_c[6]) begin
			sum_s7   <= S_W'(sq_s6[0]) + S_W'(sq_s6[1]) + S_W'(sq_s6[2]);
			u_s7     <= u_s6;
			neg_s7   <= neg_s6;
			degen_s7 <= degen_s6;
		end
	end

	always_comb begin
		out_data.rem   = sum_s7;
		out_data.res   = '0;
		out_data.u     = u_s7;
		out_data.neg   = neg_s7;
		out_data.degen = degen_s7;
	end

endmodule

// File: hdl/tfn_sqrt_cell.sv
module tfn_sqrt_cell
	import tfn_pkg::*;
#(
	parameter int K = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sq_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output sq_t  out_data
);

	localparam logic [S_W-1:0] BIT = S_W'(1) << (2 * K);

	logic vld_q;
	sq_t  data_q, next_c;
	logic [S_W-1:0] trial_c;

	assign in_ready  = ~vld_q | out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_comb begin
		next_c  = in_data;
		trial_c = in_data.res + BIT;
		if (in_data.rem >= trial_c) begin
			next_c.rem = in_data.rem - trial_c;
			next_c.res = (in_data.res >> 1) + BIT;
		end else begin
			next_c.res = in_data.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_q <= next_c;
	end

endmodule

// File: hdl/tfn_div_cell.sv
module tfn_div_cell
	import tfn_pkg::*;
#(
	parameter int J = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic vld_q;
	div_t data_q, next_c;
	logic [REM_W-1:0] dsh_c;

	assign in_ready  = ~vld_q | out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;
	assign dsh_c     = REM_W'(in_data.d) << J;

	always_comb begin
		next_c = in_data;
		for (int i = 0; i < 3; i++) begin
			if (in_data.rem[i] >= dsh_c) begin
				next_c.rem[i]  = in_data.rem[i] - dsh_c;
				next_c.q[i][J] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) data_q <= next_c;
	end

endmodule

// File: hdl/triangle_face_normal_top.sv
// triangle face normal: one triangle in, one unit normal out
// slave side s_tvalid/s_tready/s_tdata carries the nine vertex coordinates,
// signed q8.8, vertex0_x in the lowest 16 bits up to vertex2_z
// master side m_tvalid/m_tready/m_tdata carries normal_x, normal_y, normal_z
// in signed q1.14, m_tuser is the degenerate flag (zero normal)
// a request is taken when tvalid and tready are both high
// the pipeline is 7 front stages (edges, products, cross, leading one,
// normalise, squares, sum), 31 square root cells with one result bit each,
// then 16 divider cells with one quotient bit each for all three components
// throughput is one triangle per cycle while m_tready is high, every stage holds one request
// when the receiver stalls the last cell holds its result and each stage
// keeps taking requests until it is full, bubbles close up on the way
// reset clears only the valid flags, the pipeline comes up empty
module triangle_face_normal_top
	import tfn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // vertex0_x/y/z, vertex1_x/y/z, vertex2_x/y/z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // normal_x, normal_y, normal_z
	output logic         m_tuser   // degenerate
);

	localparam int DIV_STEPS = Q_W;
	localparam logic [Q_W-1:0] LIM = Q_W'(1) << FRAC_W;

	sq_t  sq_d [ROOT_STEPS+1];
	logic sq_v [ROOT_STEPS+1];
	logic sq_r [ROOT_STEPS+1];
	div_t dv_d [DIV_STEPS+1];
	logic dv_v [DIV_STEPS+1];
	logic dv_r [DIV_STEPS+1];

	logic [8:0][COORD_W-1:0] vtx_c;
	logic [L_W-1:0]          len_c;
	logic [Q_W-1:0]          n_c [3];

	assign vtx_c = s_tdata;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_vtx    (vtx_c),
		.out_valid (sq_v[0]),
		.out_ready (sq_r[0]),
		.out_data  (sq_d[0])
	);

	genvar g;
	generate
		for (g = 0; g < ROOT_STEPS; g++) begin : g_sqrt
			tfn_sqrt_cell #(.K(ROOT_STEPS - 1 - g)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (sq_v[g]),
				.in_ready  (sq_r[g]),
				.in_data   (sq_d[g]),
				.out_valid (sq_v[g+1]),
				.out_ready (sq_r[g+1]),
				.out_data  (sq_d[g+1])
			);
		end
	endgenerate

	assign len_c = sq_d[ROOT_STEPS].res[L_W-1:0];
	assign dv_v[0] = sq_v[ROOT_STEPS];
	assign sq_r[ROOT_STEPS] = dv_r[0];

	always_comb begin
		dv_d[0].d     = {len_c, 1'b0};
		dv_d[0].neg   = sq_d[ROOT_STEPS].neg;
		dv_d[0].degen = sq_d[ROOT_STEPS].degen;
		for (int i = 0; i < 3; i++) begin
			dv_d[0].rem[i] = {sq_d[ROOT_STEPS].u[i], {(FRAC_W + 1){1'b0}}}
			               + REM_W'(len_c);
			dv_d[0].q[i]   = '0;
		end
	end

	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_div
			tfn_div_cell #(.J(DIV_STEPS - 1 - g)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (dv_v[g]),
				.in_ready  (dv_r[g]),
				.in_data   (dv_d[g]),
				.out_valid (dv_v[g+1]),
				.out_ready (dv_r[g+1]),
				.out_data  (dv_d[g+1])
			);
		end
	endgenerate

	assign m_tvalid        = dv_v[DIV_STEPS];
	assign dv_r[DIV_STEPS] = m_tready;
	assign m_tuser         = dv_d[DIV_STEPS].degen;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = (dv_d[DIV_STEPS].q[i] > LIM) ? LIM : dv_d[DIV_STEPS].q[i];
			if (dv_d[DIV_STEPS].neg[i]) n_c[i] = -n_c[i];
			if (dv_d[DIV_STEPS].degen) n_c[i] = '0;
		end
	end

	assign m_tdata = {OUT_W'(n_c[2]), OUT_W'(n_c[1]), OUT_W'(n_c[0])};

endmodule

// File: tb/sv/triangle_face_normal_checker.sv
module triangle_face_normal_checker
	import tfn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending,
	output int           normals_seen,
	output int           degen_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
	} normal_t;

	normal_t normal_q[$];

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic normal_t face_normal(logic [143:0] tri_in);
		longint v[9];
		longint e[6];
		longint c[3];
		longint unsigned u[3];
		longint unsigned m;
		longint unsigned s;
		longint unsigned len;
		longint unsigned n;
		logic [15:0] comp[3];
		normal_t r;
		for (int i = 0; i < 9; i++)
			v[i] = longint'($signed(tri_in[16*i +: 16]));
		for (int i = 0; i < 3; i++) begin
			e[i] = v[i] - v[3+i];
			e[3+i] = v[3+i] - v[6+i];
		end
		// edges of 16-bit vertices never need prescaling
		c[0] = e[1]*e[5] - e[2]*e[4];
		c[1] = e[2]*e[3] - e[0]*e[5];
		c[2] = e[0]*e[4] - e[1]*e[3];
		r = '0;
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			r.degen = 1'b1;
			return r;
		end
		m = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = c[i] < 0 ? -c[i] : c[i];
			if (u[i] > m)
				m = u[i];
		end
		if (m < (64'd1 << 29)) begin
			while (m < (64'd1 << 29)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++)
					u[i] <<= 1;
			end
		end else begin
			while (m >= (64'd1 << 30)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++)
					u[i] >>= 1;
			end
		end
		s = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
		len = root_floor(s);
		for (int i = 0; i < 3; i++) begin
			n = ((u[i] << (FRAC_W + 1)) + len) / (2 * len);
			if (n > (64'd1 << FRAC_W))
				n = 64'd1 << FRAC_W;
			if (c[i] < 0)
				n = -n;
			comp[i] = n[15:0];
		end
		r.nx = comp[0];
		r.ny = comp[1];
		r.nz = comp[2];
		return r;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		normals_seen = 0;
		degen_seen = 0;
	end

	assign pending = normal_q.size();

	always @(posedge clk) begin
		normal_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				normal_q.push_back(face_normal(s_tdata));
			if (m_tvalid && m_tready) begin
				normals_seen++;
				if (m_tuser)
					degen_seen++;
				if (normal_q.size() == 0) begin
					report("unexpected normal", m_tdata[15:0], 16'd0);
				end else begin
					want = normal_q.pop_front();
					if (m_tdata[15:0] !== want.nx)
						report("normal_x", m_tdata[15:0], want.nx);
					if (m_tdata[31:16] !== want.ny)
						report("normal_y", m_tdata[31:16], want.ny);
					if (m_tdata[47:32] !== want.nz)
						report("normal_z", m_tdata[47:32], want.nz);
					if (m_tuser !== want.degen)
						report("degenerate", {15'd0, m_tuser}, {15'd0, want.degen});
				end
			end
		end
	end
endmodule

// File: tb/sv/triangle_face_normal_top_tb.sv
module triangle_face_normal_top_tb;
	import tfn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 54;
	localparam int IDLE_LIMIT = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         m_tuser;
	int           fail_count;
	int           pending;
	int           normals_seen;
	int           degen_seen;
	int           idle_cycles;
	logic         hold_off;
	logic         sending;

	triangle_face_normal_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	triangle_face_normal_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .fail_count(fail_count), .pending(pending),
		.normals_seen(normals_seen), .degen_seen(degen_seen)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] coord_rand();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// request with one coordinate per vertex field
	task automatic send_tri(logic [143:0] tri_in);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tdata <= tri_in;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop offering and wait until every result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic send_rand_tri();
		logic [143:0] t;
		logic [15:0] base;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			t[16*i +: 16] = coord_rand();
		if (kind == 0) begin
			// collinear: vertex2 repeats vertex1
			t[143:96] = t[95:48];
		end else if (kind == 1) begin
			for (int i = 0; i < 3; i++) begin
				base = 16'($urandom);
				t[16*i +: 16] = base;
				t[16*(i+3) +: 16] = base + 16'($urandom_range(0, 3));
				t[16*(i+6) +: 16] = base + 16'($urandom_range(0, 3));
			end
		end
		send_tri(t);
	endtask

	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (sending || pending != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (300) @(negedge clk);
		hold_off = 1'b1;
		repeat (200) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		logic [143:0] t;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		idle_cycles = 0;
		sending = 1'b1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_tri('0);
		send_tri({48'h0, 48'h0, {16'h0100, 16'h0000, 16'h0000}});
		send_tri({{16'h0, 16'h0100, 16'h0}, 48'h0, {16'h0, 16'h0, 16'h0100}});
		send_tri({{3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}});
		send_tri({{16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000},
			{16'h7fff, 16'h7fff, 16'h8000}});
		send_tri({{16'h0, 16'h0, 16'h0001}, {16'h0, 16'h0001, 16'h0}, {16'h0001, 16'h0, 16'h0}});
		send_tri({{16'h8000, 16'h0, 16'h0}, {16'h0, 16'h7fff, 16'h0}, {16'h0, 16'h0, 16'h8000}});
		send_tri({{16'hffff, 16'hffff, 16'hffff}, {16'h0, 16'h0, 16'h0}, {16'h0001, 16'h0001, 16'h0001}});
		send_tri({{16'h0, 16'h0, 16'h0002}, 48'h0, {16'h0, 16'h0, 16'h0001}});
		send_tri({{3{16'h1234}}, {3{16'h1234}}, {3{16'h1234}}});
		for (int i = 0; i < 10; i++) begin
			for (int k = 0; k < 9; k++)
				t[16*k +: 16] = coord_rand();
			send_tri(t);
		end
		// drain fully before the random run
		drain();
		for (int n = 0; n < 1600; n++) begin
			send_rand_tri();
			if (n == 800)
				drain();
		end
		drain();
		sending = 1'b0;
		repeat (LATENCY + 10) @(negedge clk);
		$display("covered %0d normals, %0d degenerate, incl. a long output stall",
			normals_seen, degen_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
